// ----- rtl/rpb_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB pixel blend package
// Item types, blend mode codes and fixed constants shared by the blend unit.
// ----------------------------------------------------------------------------
package rpb_pkg;

    typedef enum logic [1:0] {
        CMD_MULTIPLY = 2'd0,
        CMD_SUBTRACT = 2'd1,
        CMD_SCREEN   = 2'd2,
        CMD_OVERLAY  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd       command;
        logic [7:0] a_red;
        logic [7:0] a_green;
        logic [7:0] a_blue;
        logic [7:0] b_red;
        logic [7:0] b_green;
        logic [7:0] b_blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } t_out_item;

    // Channel full scale and the overlay dark/light threshold on the top channel
    localparam logic [7:0]  CH_MAX        = 8'd255;
    localparam logic [7:0]  OVL_THRESHOLD = 8'd127;
    // Half of 255 rounded down: round(x/255) = floor((x + RND_BIAS) / 255)
    localparam logic [15:0] RND_BIAS      = 16'd127;
    // 255*255 + RND_BIAS, used by screen and the light overlay branch
    localparam logic [15:0] FULL_BIAS     = 16'd65152;

endpackage

// ----- rtl/rpb_lane.sv -----
// ----------------------------------------------------------------------------
// RGB pixel blend lane
// Three-stage blend of one 8-bit channel: multiply, bias, divide by 255, or a clamped subtract.
// ----------------------------------------------------------------------------
module rpb_lane (
    input  logic          i_clk,
    input  rpb_pkg::t_cmd i_cmd,
    input  logic [7:0]    i_a,
    input  logic [7:0]    i_b,
    output logic [7:0]    o_res
);

    typedef enum logic [2:0] {
        K_DIRECT,   // a*b
        K_DOUBLE,   // 2ab, dark overlay
        K_SCREEN,   // full - p
        K_LIGHT,    // full - 2p, light overlay, may go below zero
        K_SUB       // a-b clamped
    } t_kind;

    // stage 1
    t_kind       n_kind, r_kind;
    logic [15:0] n_prod, r_prod;
    logic [7:0]  n_sub,  r_sub;
    logic        w_inv;
    logic [7:0]  w_ma, w_mb;

    // stage 2
    logic [15:0] n_num, r_num;
    logic        n_is_sub, r_is_sub;
    logic [7:0]  r_sub2;
    logic [17:0] w_light;

    // stage 3
    logic [16:0] w_sum;
    logic [8:0]  w_q1;
    logic [16:0] w_p255;
    logic [17:0] w_rem;
    logic [8:0]  w_q;
    logic [7:0]  w_sat;
    logic [7:0]  n_res, r_res;

    always_comb begin
        case (i_cmd)
            rpb_pkg::CMD_MULTIPLY: n_kind = K_DIRECT;
            rpb_pkg::CMD_SUBTRACT: n_kind = K_SUB;
            rpb_pkg::CMD_SCREEN:   n_kind = K_SCREEN;
            rpb_pkg::CMD_OVERLAY:  n_kind = (i_a < rpb_pkg::OVL_THRESHOLD) ? K_DOUBLE : K_LIGHT;
            default:               n_kind = K_DIRECT;
        endcase
        w_inv  = (n_kind == K_SCREEN) || (n_kind == K_LIGHT);
        // 255 - x is the complement for 8-bit x
        w_ma   = w_inv ? ~i_a : i_a;
        w_mb   = w_inv ? ~i_b : i_b;
        n_prod = 16'(w_ma) * 16'(w_mb);
        n_sub  = (i_a > i_b) ? (i_a - i_b) : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_prod <= n_prod;
        r_sub  <= n_sub;
    end

    always_comb begin
        w_light  = {2'b00, rpb_pkg::FULL_BIAS} - {1'b0, r_prod, 1'b0};
        n_is_sub = (r_kind == K_SUB);
        case (r_kind)
            K_DIRECT: n_num = r_prod + rpb_pkg::RND_BIAS;
            K_DOUBLE: n_num = 16'({r_prod, 1'b0} + {1'b0, rpb_pkg::RND_BIAS});
            K_SCREEN: n_num = rpb_pkg::FULL_BIAS - r_prod;
            K_LIGHT:  n_num = w_light[17] ? 16'd0 : w_light[15:0];   // below zero saturates
            default:  n_num = 16'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_num    <= n_num;
        r_is_sub <= n_is_sub;
        r_sub2   <= r_sub;
    end

    // x/255 estimate (x + x/256 + 1)/256 is within one; one remainder check fixes it
    always_comb begin
        w_sum  = {1'b0, r_num} + {9'd0, r_num[15:8]} + 17'd1;
        w_q1   = w_sum[16:8];
        w_p255 = {w_q1, 8'd0} - {8'd0, w_q1};
        w_rem  = {2'b00, r_num} - {1'b0, w_p255};
        if (w_rem[17]) begin
            w_q = w_q1 - 9'd1;
        end else if (w_rem[16:0] >= 17'(rpb_pkg::CH_MAX)) begin
            w_q = w_q1 + 9'd1;
        end else begin
            w_q = w_q1;
        end
        w_sat = w_q[8] ? rpb_pkg::CH_MAX : w_q[7:0];
        n_res = r_is_sub ? r_sub2 : w_sat;
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

// ----- rtl/rpb_merge.sv -----
// ----------------------------------------------------------------------------
// RGB pixel blend merge
// Gathers the three lane results into one output item and its strobe.
// ----------------------------------------------------------------------------
module rpb_merge (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_red,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_blue,
    output logic               o_done,
    output rpb_pkg::t_out_item o_result
);

    logic               r_done;
    rpb_pkg::t_out_item n_result, r_result;

    always_comb begin
        n_result.out_red   = i_red;
        n_result.out_green = i_green;
        n_result.out_blue  = i_blue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ----- rtl/rgb_pixel_blend_unit.sv -----
// ----------------------------------------------------------------------------
// RGB pixel blend unit
// Multiply, subtract, screen and overlay blend of a top and a bottom pixel.
// ----------------------------------------------------------------------------
// Takes one item per clock: raise start with a pixel pair and a blend mode
// and it is taken at that edge (busy is never raised, the unit is fully
// pipelined). o_done then pulses for one cycle with the blended pixel on
// o_result; there is no backpressure, so the receiver must take it in that
// cycle. The result passes the three lane stages (channel multiply, rounding
// bias, divide by 255 with correction) and then the output register of the
// merge stage. Results are exact integer blends, rounded half up and
// saturated to 0..255.
// ----------------------------------------------------------------------------
module rgb_pixel_blend_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  rpb_pkg::t_in_item  i_item,
    output logic               o_done,
    output rpb_pkg::t_out_item o_result
);

    // item valid through the three lane stages
    logic [2:0] r_vld, n_vld;
    logic       w_accept;

    logic [7:0] w_res_red, w_res_green, w_res_blue;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    always_comb begin
        n_vld = {r_vld[1:0], w_accept};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // one lane per colour channel, all running the same mode
    rpb_lane u_lane_red (
        .i_clk (i_clk),
        .i_cmd (i_item.command),
        .i_a   (i_item.a_red),
        .i_b   (i_item.b_red),
        .o_res (w_res_red)
    );

    rpb_lane u_lane_green (
        .i_clk (i_clk),
        .i_cmd (i_item.command),
        .i_a   (i_item.a_green),
        .i_b   (i_item.b_green),
        .o_res (w_res_green)
    );

    rpb_lane u_lane_blue (
        .i_clk (i_clk),
        .i_cmd (i_item.command),
        .i_a   (i_item.a_blue),
        .i_b   (i_item.b_blue),
        .o_res (w_res_blue)
    );

    rpb_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_vld[2]),
        .i_red    (w_res_red),
        .i_green  (w_res_green),
        .i_blue   (w_res_blue),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // every taken item comes out on o_done
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##4 o_done)
        else $error("accepted item produced no result");

    // no result without a matching item taken before it
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_accept, 4))
        else $error("result without matching item");

    // subtract on red matches its inputs through the pipeline
    a_sub_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ($past(i_item.command, 4) == rpb_pkg::CMD_SUBTRACT)) |->
        (o_result.out_red == (($past(i_item.a_red, 4) > $past(i_item.b_red, 4)) ?
            ($past(i_item.a_red, 4) - $past(i_item.b_red, 4)) : 8'd0)))
        else $error("subtract result wrong on red");

    // multiply by full scale returns the top channel
    a_mul_unity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ($past(i_item.command, 4) == rpb_pkg::CMD_MULTIPLY) &&
         ($past(i_item.b_green, 4) == rpb_pkg::CH_MAX)) |->
        (o_result.out_green == $past(i_item.a_green, 4)))
        else $error("multiply by full scale wrong on green");

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// RGB pixel blend unit testbench
// Drives pixel pairs with every blend mode through the unit and checks each
// blended pixel against a local integer model of the four blend modes.
// ----------------------------------------------------------------------------
// Directed corner pixels come first, then three random bursts: light sender
// gaps, heavy sender gaps with periodic full drains, and back-to-back items.
// Inputs change on the falling edge and outputs are sampled on the rising
// edge. Each accepted item writes its predicted pixel into a small ring and
// each o_done pulse reads the oldest one. A watchdog ends the run if nothing
// moves for too long.
// ----------------------------------------------------------------------------
module tb;

    localparam int STALL_LIMIT  = 2000;  // cycles with no item moving
    localparam int FLUSH_CYCLES = 12;    // margin after the final drain
    localparam int MAX_REPORTS  = 10;
    localparam int BURST_ITEMS  = 575;
    localparam int DRAIN_EVERY  = 100;
    localparam int PEND_DEPTH   = 64;    // far above the four items in flight

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    logic                busy;
    rpb_pkg::t_in_item   i_item  = '0;
    logic                o_done;
    rpb_pkg::t_out_item  o_result;

    rpb_pkg::t_out_item  pending_pixels [PEND_DEPTH];  // predicted pixels, ring
    int         pend_wr       = 0;  // items predicted so far
    int         pend_rd       = 0;  // results checked so far
    int         fault_count   = 0;
    int         stall_cycles  = 0;
    int         sender_idle_pct = 0;

    rgb_pixel_blend_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Blend model
    // ------------------------------------------------------------------------

    // Nearest integer of x/255, ties up (no true ties occur for /255)
    function automatic int unsigned div255_round(input int unsigned x);
        int unsigned cmax;
        cmax = 32'(rpb_pkg::CH_MAX);
        return (2 * x + cmax) / (2 * cmax);
    endfunction

    function automatic logic [7:0] blend_lane(input rpb_pkg::t_cmd mode,
                                              input logic [7:0] a,
                                              input logic [7:0] b);
        int unsigned cmax, ua, ub, full, inv, lit, sq, r;
        cmax = 32'(rpb_pkg::CH_MAX);
        ua   = 32'(a);
        ub   = 32'(b);
        full = cmax * cmax;
        inv  = (cmax - ua) * (cmax - ub);
        case (mode)
            rpb_pkg::CMD_MULTIPLY: r = div255_round(ua * ub);
            rpb_pkg::CMD_SUBTRACT: r = (ua > ub) ? ua - ub : 0;
            rpb_pkg::CMD_SCREEN:   r = div255_round(full - inv);
            default: begin
                // Overlay: branch chosen by the top channel alone
                if (ua < 32'(rpb_pkg::OVL_THRESHOLD)) begin
                    r = div255_round(2 * ua * ub);
                end else begin
                    // 255 - 2p/255 rounded; can dip below zero at a=127, b=0
                    lit = 2 * full + cmax;
                    sq  = 4 * inv;
                    r   = (sq > lit) ? 0 : (lit - sq) / (2 * cmax);
                end
            end
        endcase
        if (r > cmax) r = cmax;
        return r[7:0];
    endfunction

    function automatic rpb_pkg::t_out_item blend_pixel(input rpb_pkg::t_in_item px);
        rpb_pkg::t_out_item q;
        q.out_red   = blend_lane(px.command, px.a_red,   px.b_red);
        q.out_green = blend_lane(px.command, px.a_green, px.b_green);
        q.out_blue  = blend_lane(px.command, px.a_blue,  px.b_blue);
        return q;
    endfunction

    // ------------------------------------------------------------------------
    // Item building
    // ------------------------------------------------------------------------

    function automatic rpb_pkg::t_in_item make_pixel(input rpb_pkg::t_cmd mode,
                                            input logic [7:0] ar, input logic [7:0] ag,
                                            input logic [7:0] ab, input logic [7:0] br,
                                            input logic [7:0] bg, input logic [7:0] bb);
        rpb_pkg::t_in_item px;
        px.command = mode;
        px.a_red   = ar;
        px.a_green = ag;
        px.a_blue  = ab;
        px.b_red   = br;
        px.b_green = bg;
        px.b_blue  = bb;
        return px;
    endfunction

    // Biased towards the rails and the overlay threshold
    function automatic logic [7:0] pick_channel();
        logic [7:0] corners [7];
        corners = '{8'd0, 8'd1, 8'd126, 8'd127, 8'd128, 8'd254, 8'd255};
        if ($urandom_range(99) < 30) return corners[$urandom_range(6)];
        return 8'($urandom_range(255));
    endfunction

    function automatic rpb_pkg::t_in_item random_pixel();
        return make_pixel(rpb_pkg::t_cmd'($urandom_range(3)),
                          pick_channel(), pick_channel(), pick_channel(),
                          pick_channel(), pick_channel(), pick_channel());
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Called just after a rising edge; returns at the edge that takes the item
    task automatic send_pixel(input rpb_pkg::t_in_item px);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            i_item <= random_pixel();  // junk while idle, must be ignored
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= px;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_pixels[pend_wr % PEND_DEPTH] = blend_pixel(px);
        pend_wr++;
    endtask

    // Stop sending and wait until every predicted pixel has come back
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pend_wr != pend_rd) @(posedge i_clk);
    endtask

    task automatic random_burst(input int count, input int idle_pct, input int drain_every);
        sender_idle_pct = idle_pct;
        for (int n = 1; n <= count; n++) begin
            send_pixel(random_pixel());
            if (drain_every != 0 && n % drain_every == 0) drain_results();
        end
    endtask

    // ------------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------------

    task automatic log_fault(input string msg);
        if (fault_count < MAX_REPORTS) $display("MISMATCH: %s", msg);
        fault_count++;
    endtask

    always @(posedge i_clk) begin
        rpb_pkg::t_out_item want;
        if (i_rst_n && o_done) begin
            if (pend_wr == pend_rd) begin
                log_fault($sformatf("result %h with none outstanding", o_result));
            end else begin
                want = pending_pixels[pend_rd % PEND_DEPTH];
                pend_rd++;
                if (o_result.out_red !== want.out_red)
                    log_fault($sformatf("out_red exp %0d got %0d",
                                        want.out_red, o_result.out_red));
                if (o_result.out_green !== want.out_green)
                    log_fault($sformatf("out_green exp %0d got %0d",
                                        want.out_green, o_result.out_green));
                if (o_result.out_blue !== want.out_blue)
                    log_fault($sformatf("out_blue exp %0d got %0d",
                                        want.out_blue, o_result.out_blue));
            end
        end
    end

    // Watchdog: anything accepted on either side resets the count
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_directed();
        sender_idle_pct = 0;
        // multiply: rails, and products just either side of a half step
        send_pixel(make_pixel(rpb_pkg::CMD_MULTIPLY, 0, 255, 255, 0, 0, 255));
        send_pixel(make_pixel(rpb_pkg::CMD_MULTIPLY, 1, 2, 128, 127, 64, 128));
        send_pixel(make_pixel(rpb_pkg::CMD_MULTIPLY, 255, 254, 1, 255, 254, 1));
        // subtract: below, equal, above, full swing
        send_pixel(make_pixel(rpb_pkg::CMD_SUBTRACT, 10, 77, 200, 11, 77, 199));
        send_pixel(make_pixel(rpb_pkg::CMD_SUBTRACT, 255, 0, 0, 0, 255, 0));
        send_pixel(make_pixel(rpb_pkg::CMD_SUBTRACT, 255, 255, 128, 255, 1, 127));
        // screen
        send_pixel(make_pixel(rpb_pkg::CMD_SCREEN, 0, 255, 0, 0, 0, 255));
        send_pixel(make_pixel(rpb_pkg::CMD_SCREEN, 128, 127, 1, 128, 128, 1));
        send_pixel(make_pixel(rpb_pkg::CMD_SCREEN, 255, 254, 253, 255, 1, 2));
        // overlay: light branch dipping below zero is saturated to 0
        send_pixel(make_pixel(rpb_pkg::CMD_OVERLAY, 127, 127, 127, 0, 0, 0));
        // overlay threshold sits on the top channel only
        send_pixel(make_pixel(rpb_pkg::CMD_OVERLAY, 126, 127, 128, 255, 255, 255));
        send_pixel(make_pixel(rpb_pkg::CMD_OVERLAY, 126, 127, 128, 1, 1, 1));
        send_pixel(make_pixel(rpb_pkg::CMD_OVERLAY, 0, 255, 255, 255, 0, 255));
        send_pixel(make_pixel(rpb_pkg::CMD_OVERLAY, 0, 1, 254, 0, 128, 254));
        send_pixel(make_pixel(rpb_pkg::CMD_OVERLAY, 64, 200, 100, 200, 64, 128));
        // every bit high then low on all fields, then alternating bit patterns
        send_pixel(make_pixel(rpb_pkg::CMD_OVERLAY, 255, 255, 255, 255, 255, 255));
        send_pixel(make_pixel(rpb_pkg::CMD_MULTIPLY, 0, 0, 0, 0, 0, 0));
        send_pixel(make_pixel(rpb_pkg::CMD_SCREEN, 170, 85, 170, 85, 170, 85));
        send_pixel(make_pixel(rpb_pkg::CMD_SUBTRACT, 85, 170, 85, 170, 85, 170));
        drain_results();
    endtask

    task automatic test_light_gaps();
        random_burst(BURST_ITEMS, 10, 0);
    endtask

    // Heavy gaps, and the sender now and then waits for a full drain
    task automatic test_heavy_gaps();
        random_burst(BURST_ITEMS, 45, DRAIN_EVERY);
    endtask

    task automatic test_back_to_back();
        random_burst(BURST_ITEMS, 0, 0);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_light_gaps();
        test_heavy_gaps();
        test_back_to_back();

        drain_results();
        repeat (FLUSH_CYCLES) @(posedge i_clk);

        if (fault_count == 0 && pend_wr == pend_rd) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
